>>> sv/euler_to_quaternion_core_defines.svh
// ---------------------------------------------------------------------------
// euler_to_quaternion_core_defines
// Assertion macros for the Euler-to-quaternion core.
// ---------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_CORE_DEFINES_SVH
`define EULER_TO_QUATERNION_CORE_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle
`define E2Q_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Assert that a condition implies a consequence in the next cycle
`define E2Q_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> sv/e2q_pkg.sv
// ---------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and tables of the Euler-to-quaternion core.
// ---------------------------------------------------------------------------
`default_nettype none
package e2q_pkg;
   localparam int CORDIC_ITERATIONS = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int ITERS = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
   localparam int ANG_W = 16;
   localparam int Q_W = 16;
   // Q30 datapath, sign plus headroom for CORDIC growth
   localparam int D_W = 33;
   localparam int QUARTER_UNITS = 11520;
   localparam int HALF_TURN_UNITS = 23040;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint GAIN_Q30 = 64'sd652032874;
   // pi / 23040 split into its whole part and remainder
   localparam longint unsigned RADIAN_A = PI_Q30 / 64'd23040;
   localparam longint unsigned RADIAN_B = PI_Q30 % 64'd23040;
   // floor(t / 45) = (t * DIV45_M) >> DIV45_SH for t below 2^19
   localparam int DIV45_SH = 25;
   localparam longint unsigned DIV45_M = ((64'd1 << DIV45_SH) + 64'd44) / 64'd45;

   typedef logic signed [D_W-1:0] data_type;

   typedef struct packed {
      data_type x;
      data_type y;
      data_type z;
      logic     flip;
   } cell_lane_type;

   typedef struct packed {
      cell_lane_type [2:0] lane;
   } cell_data_type;

   function automatic data_type atan_q30(input logic [4:0] idx);
      case (idx)
         5'd0: atan_q30 = 33'sd843314856;
         5'd1: atan_q30 = 33'sd497837829;
         5'd2: atan_q30 = 33'sd263043836;
         5'd3: atan_q30 = 33'sd133525158;
         5'd4: atan_q30 = 33'sd67021686;
         5'd5: atan_q30 = 33'sd33543515;
         5'd6: atan_q30 = 33'sd16775850;
         5'd7: atan_q30 = 33'sd8388437;
         5'd8: atan_q30 = 33'sd4194282;
         5'd9: atan_q30 = 33'sd2097149;
         5'd10: atan_q30 = 33'sd1048575;
         5'd11: atan_q30 = 33'sd524287;
         5'd12: atan_q30 = 33'sd262143;
         5'd13: atan_q30 = 33'sd131071;
         5'd14: atan_q30 = 33'sd65535;
         5'd15: atan_q30 = 33'sd32767;
         5'd16: atan_q30 = 33'sd16383;
         5'd17: atan_q30 = 33'sd8191;
         5'd18: atan_q30 = 33'sd4095;
         5'd19: atan_q30 = 33'sd2047;
         5'd20: atan_q30 = 33'sd1023;
         5'd21: atan_q30 = 33'sd511;
         5'd22: atan_q30 = 33'sd255;
         5'd23: atan_q30 = 33'sd127;
         default: atan_q30 = '0;
      endcase
   endfunction
endpackage
`default_nettype wire

>>> sv/e2q_stream_if.sv
// ---------------------------------------------------------------------------
// e2q_stream_if
// Valid/ready channel carrying one payload of a given width.
// ---------------------------------------------------------------------------
`default_nettype none
interface e2q_stream_if #(parameter int WIDTH = 48) (input wire logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/e2q_cordic_cell.sv
// ---------------------------------------------------------------------------
// e2q_cordic_cell
// One CORDIC micro-rotation for all three angle lanes, registered.
// ---------------------------------------------------------------------------
`default_nettype none
module e2q_cordic_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic [4:0]             step,
   input  wire logic                   valid_in,
   input  e2q_pkg::cell_data_type      data_in,
   output logic                        valid_out,
   output e2q_pkg::cell_data_type      data_out
);
   e2q_pkg::cell_data_type data_in_c;
   e2q_pkg::data_type      atan_val;
   logic                   valid_ff;
   e2q_pkg::cell_data_type data_ff;

   assign atan_val = e2q_pkg::atan_q30(step);

   // rotate each lane toward zero residual angle
   always_comb begin
      data_in_c = data_in;
      for (int k = 0; k < 3; k++) begin
         if (!data_in.lane[k].z[e2q_pkg::D_W-1]) begin
            data_in_c.lane[k].x = data_in.lane[k].x - (data_in.lane[k].y >>> step);
            data_in_c.lane[k].y = data_in.lane[k].y + (data_in.lane[k].x >>> step);
            data_in_c.lane[k].z = data_in.lane[k].z - atan_val;
         end else begin
            data_in_c.lane[k].x = data_in.lane[k].x + (data_in.lane[k].y >>> step);
            data_in_c.lane[k].y = data_in.lane[k].y - (data_in.lane[k].x >>> step);
            data_in_c.lane[k].z = data_in.lane[k].z + atan_val;
         end
      end
   end

   // advance when the chain moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         data_ff <= data_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
endmodule
`default_nettype wire

>>> sv/e2q_front.sv
// ---------------------------------------------------------------------------
// e2q_front
// Folds each half angle and scales it to Q30 radians over three stages.
// ---------------------------------------------------------------------------
`default_nettype none
module e2q_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           enable,
   input  wire logic                           valid_in,
   input  wire logic [3*e2q_pkg::ANG_W-1:0]    angles,
   output logic                                valid_out,
   output e2q_pkg::cell_data_type              data_out
);
   logic               valid_a_ff, valid_b_ff, valid_c_ff;
   logic [14:0]        mag_a_ff [3];
   logic               neg_a_ff [3];
   logic               flip_a_ff [3];
   logic [31:0]        whole_b_ff [3];
   logic [18:0]        part_b_ff [3];
   logic               neg_b_ff [3];
   logic               flip_b_ff [3];
   e2q_pkg::cell_data_type data_c_ff;

   // stage 1: fold and take magnitude
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            logic signed [17:0] h;
            logic signed [17:0] f;
            logic               fl;
            h = 18'(signed'(angles[k*e2q_pkg::ANG_W +: e2q_pkg::ANG_W]));
            fl = 1'b1;
            if (h > 18'sd11520) f = 18'sd23040 - h;
            else if (h < -18'sd11520) f = -18'sd23040 - h;
            else begin
               f = h;
               fl = 1'b0;
            end
            neg_a_ff[k]  <= f[17];
            mag_a_ff[k]  <= f[17] ? 15'(-f) : 15'(f);
            flip_a_ff[k] <= fl;
         end
      end
   end

   // stage 2: whole part of mag * pi / 23040, remainder scaled down by 512
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            logic [27:0] rest;
            rest = 28'(mag_a_ff[k]) * 28'(e2q_pkg::RADIAN_B)
                 + 28'(e2q_pkg::HALF_TURN_UNITS / 2);
            whole_b_ff[k] <= 32'(mag_a_ff[k]) * 32'(e2q_pkg::RADIAN_A);
            part_b_ff[k]  <= rest[27:9];
            neg_b_ff[k]   <= neg_a_ff[k];
            flip_b_ff[k]  <= flip_a_ff[k];
         end
      end
   end

   // stage 3: divide the remainder by 45 via reciprocal and restore the sign
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            logic [38:0] prod;
            logic [31:0] q;
            prod = 39'(part_b_ff[k]) * 39'(e2q_pkg::DIV45_M);
            q    = whole_b_ff[k] + 32'(prod >> e2q_pkg::DIV45_SH);
            data_c_ff.lane[k].x    <= e2q_pkg::data_type'(e2q_pkg::GAIN_Q30);
            data_c_ff.lane[k].y    <= '0;
            data_c_ff.lane[k].z    <= neg_b_ff[k] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            data_c_ff.lane[k].flip <= flip_b_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= valid_in;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   assign valid_out = valid_c_ff;
   assign data_out  = data_c_ff;
endmodule
`default_nettype wire

>>> sv/e2q_combine.sv
// ---------------------------------------------------------------------------
// e2q_combine
// Forms the quaternion from sines and cosines with rounded Q30 products.
// ---------------------------------------------------------------------------
`default_nettype none
module e2q_combine (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        enable,
   input  wire logic                        valid_in,
   input  e2q_pkg::cell_data_type           data_in,
   output logic                             valid_out,
   output logic [4*e2q_pkg::Q_W-1:0]        quat
);
   typedef logic signed [32:0] v_type;
   localparam int SH = 30 - e2q_pkg::OUT_FRAC_BITS;

   logic  [2:0] valid_ff;
   v_type cy_ff, sy_ff, cp_ff, sp_ff, cr_ff, sr_ff;
   v_type p_ff [4];
   v_type t_ff [2];
   logic [4*e2q_pkg::Q_W-1:0] quat_ff;

   function automatic v_type mulq(input v_type a, input v_type b);
      logic signed [65:0] m;
      m = 66'(a) * 66'(b) + 66'sd536870912;
      return v_type'(m >>> 30);
   endfunction

   function automatic logic [15:0] to_out(input logic signed [34:0] v);
      logic signed [34:0] r;
      logic signed [34:0] one;
      one = 35'sd1 <<< e2q_pkg::OUT_FRAC_BITS;
      r = v;
      if (SH > 0) r = (v + (35'sd1 <<< (SH - 1))) >>> SH;
      if (r > one) r = one;
      if (r < -one) r = -one;
      if (r > 35'sd32767) r = 35'sd32767;
      if (r < -35'sd32768) r = -35'sd32768;
      return r[15:0];
   endfunction

   // stage 1: sin and cos of each half angle, cosine sign restored
   always_ff @(posedge clock) begin
      if (enable) begin
         cy_ff <= data_in.lane[0].flip ? -data_in.lane[0].x : data_in.lane[0].x;
         sy_ff <= data_in.lane[0].y;
         cp_ff <= data_in.lane[1].flip ? -data_in.lane[1].x : data_in.lane[1].x;
         sp_ff <= data_in.lane[1].y;
         cr_ff <= data_in.lane[2].flip ? -data_in.lane[2].x : data_in.lane[2].x;
         sr_ff <= data_in.lane[2].y;
      end
   end

   // stage 2: yaw times pitch
   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff[0] <= mulq(cy_ff, cp_ff);
         p_ff[1] <= mulq(sy_ff, sp_ff);
         p_ff[2] <= mulq(sy_ff, cp_ff);
         p_ff[3] <= mulq(cy_ff, sp_ff);
         t_ff[0] <= cr_ff;
         t_ff[1] <= sr_ff;
      end
   end

   // stage 3: roll times pair, sum and saturate
   always_ff @(posedge clock) begin
      if (enable) begin
         quat_ff[0*16 +: 16] <= to_out(35'(mulq(t_ff[0], p_ff[0])) + 35'(mulq(t_ff[1], p_ff[1])));
         quat_ff[1*16 +: 16] <= to_out(35'(mulq(t_ff[0], p_ff[2])) - 35'(mulq(t_ff[1], p_ff[3])));
         quat_ff[2*16 +: 16] <= to_out(35'(mulq(t_ff[0], p_ff[3])) + 35'(mulq(t_ff[1], p_ff[2])));
         quat_ff[3*16 +: 16] <= to_out(35'(mulq(t_ff[1], p_ff[0])) - 35'(mulq(t_ff[0], p_ff[1])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[1:0], valid_in};
      end
   end

   assign valid_out = valid_ff[2];
   assign quat      = quat_ff;
endmodule
`default_nettype wire

>>> sv/euler_to_quaternion_core.sv
// ---------------------------------------------------------------------------
// euler_to_quaternion_core
// Three Euler angles (degrees, 6 fraction bits) to a Q1.14 unit quaternion.
// ---------------------------------------------------------------------------
// One request per cycle: a pipeline of 3 front stages, one CORDIC cell per
// iteration (16), and 3 product stages. The whole chain advances when the
// output register is free or being read; a full output stalls it and holds
// req_ready low.
`default_nettype none
`include "euler_to_quaternion_core_defines.svh"
module euler_to_quaternion_core (
   input wire logic       clock,
   input wire logic       reset,
   e2q_stream_if.sink     req,
   e2q_stream_if.source   rsp
);
   localparam int N = e2q_pkg::ITERS;

   logic                   enable;
   logic                   front_valid;
   e2q_pkg::cell_data_type front_data;
   logic                   chain_valid [N+1];
   e2q_pkg::cell_data_type chain_data  [N+1];
   logic                   comb_valid;
   logic [63:0]            comb_quat;

   // advance whenever the output register is empty or being read
   assign enable    = !comb_valid || rsp.ready;
   assign req.ready = enable;

   e2q_front u_front (
      .clock(clock), .reset(reset), .enable(enable),
      .valid_in(req.valid && req.ready), .angles(req.data),
      .valid_out(front_valid), .data_out(front_data)
   );

   assign chain_valid[0] = front_valid;
   assign chain_data[0]  = front_data;

   for (genvar i = 0; i < N; i++) begin : g_cell
      e2q_cordic_cell u_cell (
         .clock(clock), .reset(reset), .enable(enable), .step(5'(i)),
         .valid_in(chain_valid[i]), .data_in(chain_data[i]),
         .valid_out(chain_valid[i+1]), .data_out(chain_data[i+1])
      );
   end

   e2q_combine u_combine (
      .clock(clock), .reset(reset), .enable(enable),
      .valid_in(chain_valid[N]), .data_in(chain_data[N]),
      .valid_out(comb_valid), .quat(comb_quat)
   );

   assign rsp.valid = comb_valid;
   assign rsp.data  = comb_quat;

   `E2Q_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(comb_quat), "result lost while stalled")
   `E2Q_ASSERT_IMPLY(a_stall, clock, reset, rsp.valid && !rsp.ready,
      !req.ready, "chain advanced over a stalled result")
endmodule
`default_nettype wire
